// ===== rtl/binary_min_heap_queue_assert.svh =====
// Assertion macros used by the heap queue RTL.
// Included by bmhq_seq, which checks its own sequencing; no other dependencies.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// implication or sequence property, off while reset is low
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// plain condition that must hold at every edge out of reset
`define BMHQ_ASSERT_INV(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMHQ_ASSERT_INV(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/bmhq_pkg.sv =====
// Types and constants of the binary min-heap queue.
// No dependencies; used by the channel interfaces, the sequencer and the top level.
package bmhq_pkg;

  localparam int KEY_WIDTH   = 32;
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CMD_W       = 2;
  localparam int ST_W        = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY        = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW     = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_DECREASE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic signed [KEY_WIDTH-1:0] key_value;
    logic [IDX_W-1:0]            heap_index;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]             status;
    logic signed [KEY_WIDTH-1:0] removed_value;
    logic signed [KEY_WIDTH-1:0] current_min;
    logic [CNT_W-1:0]            entry_total;
  } res_item_t;

endpackage

// ===== rtl/bmhq_in_if.sv =====
// Command channel of the heap queue: valid/ready plus the command fields.
// Depends on bmhq_pkg for field widths.
interface bmhq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bmhq_pkg::CMD_W-1:0]            command;
  logic signed [bmhq_pkg::KEY_WIDTH-1:0] key_value;
  logic [bmhq_pkg::IDX_W-1:0]            heap_index;

  modport source (output valid, output command, output key_value, output heap_index,
                  input ready);
  modport sink (input valid, input command, input key_value, input heap_index,
                output ready);
endinterface

// ===== rtl/bmhq_out_if.sv =====
// Result channel of the heap queue: valid/ready plus the result fields.
// Depends on bmhq_pkg for field widths.
interface bmhq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [bmhq_pkg::ST_W-1:0]             status;
  logic signed [bmhq_pkg::KEY_WIDTH-1:0] removed_value;
  logic signed [bmhq_pkg::KEY_WIDTH-1:0] current_min;
  logic [bmhq_pkg::CNT_W-1:0]            entry_total;

  modport source (output valid, output status, output removed_value, output current_min,
                  output entry_total, input ready);
  modport sink (input valid, input status, input removed_value, input current_min,
                input entry_total, output ready);
endinterface

// ===== rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bmhq_seq.sv =====
// Heap sequencer: decodes a command and walks the tree one level at a time,
// sharing one key comparator and one RAM read port. Depends on bmhq_pkg,
// bmhq_ram and binary_min_heap_queue_assert.svh.
`include "binary_min_heap_queue_assert.svh"
module bmhq_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmhq_pkg::in_item_t             in_item,
  input  logic [bmhq_pkg::CNT_W-1:0]     limit,
  output logic                           res_valid,
  input  logic                           res_take,
  output bmhq_pkg::res_item_t            res
);

  localparam int IW = bmhq_pkg::IDX_W;
  localparam int CW = bmhq_pkg::CNT_W;
  localparam int KW = bmhq_pkg::KEY_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = CW'(bmhq_pkg::MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC_CHK, S_DEL_RD, S_SU_RD, S_SU_CMP, S_SU_TOP, S_EX, S_EX_LAST,
    S_SD_L, S_SD_CL, S_SD_CR, S_SD_DEC, S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [IW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        force_r, force_nxt;
  logic signed [KW-1:0]        key_r, key_nxt;
  logic signed [KW-1:0]        best_r, best_nxt;
  logic [IW-1:0]               bidx_r, bidx_nxt;
  logic signed [KW-1:0]        root_r, root_nxt;
  logic signed [KW-1:0]        removed_r, removed_nxt;
  logic [bmhq_pkg::ST_W-1:0]   status_r, status_nxt;

  logic                        ram_we, ram_re;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [KW-1:0]               ram_wdata, ram_rdata;
  logic signed [KW-1:0]        rd_key;

  logic signed [KW-1:0]        cmp_a, cmp_b;
  logic                        cmp_lt;

  logic [IW-1:0]               par_idx, par_up;
  logic [CW-1:0]               lchild;
  logic [CW:0]                 rchild;
  logic                        l_ok, r_ok, idx_ok, full;
  logic [CW-1:0]               last_cnt;

  bmhq_ram #(
    .WIDTH(KW),
    .DEPTH(bmhq_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key   = $signed(ram_rdata);
  assign cmp_lt   = cmp_a < cmp_b;
  assign par_idx  = (pos_r - IW'(1)) >> 1;
  assign par_up   = (par_idx - IW'(1)) >> 1;
  assign lchild   = {pos_r, 1'b1};
  assign rchild   = {1'b0, pos_r, 1'b0} + (CW+1)'(2);
  assign l_ok     = lchild < count_r;
  assign r_ok     = rchild < {1'b0, count_r};
  assign idx_ok   = {1'b0, in_item.heap_index} < count_r;
  assign full     = (count_r >= limit) || (count_r >= CNT_MAX);
  assign last_cnt = count_r - CW'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status        = status_r;
    res.removed_value = removed_r;
    res.current_min   = (count_r != '0) ? root_r : '0;
    res.entry_total   = count_r;
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    force_nxt   = force_r;
    key_nxt     = key_r;
    best_nxt    = best_r;
    bidx_nxt    = bidx_r;
    root_nxt    = root_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = key_r;
    ram_re      = 1'b0;
    ram_raddr   = par_idx;
    cmp_a       = rd_key;
    cmp_b       = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_item.key_value;
          status_nxt  = bmhq_pkg::ST_OK;
          removed_nxt = '0;
          force_nxt   = (in_item.command == bmhq_pkg::CMD_DELETE);
          case (in_item.command)
            bmhq_pkg::CMD_INSERT: begin
              if (full) begin
                status_nxt = bmhq_pkg::ST_OVERFLOW;
                state_nxt  = S_DONE;
              end else begin
                pos_nxt   = count_r[IW-1:0];
                count_nxt = count_r + CW'(1);
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = in_item.key_value;
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_SU_RD;
                end
              end
            end
            bmhq_pkg::CMD_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = bmhq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                removed_nxt = root_r;
                state_nxt   = S_EX;
              end
            end
            default: begin
              // decrease and delete both start by reading the addressed entry
              if (!idx_ok) begin
                status_nxt = bmhq_pkg::ST_BAD_INDEX;
                state_nxt  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = in_item.heap_index;
                pos_nxt   = in_item.heap_index;
                state_nxt = (in_item.command == bmhq_pkg::CMD_DECREASE) ? S_DEC_CHK
                                                                        : S_DEL_RD;
              end
            end
          endcase
        end
      end

      S_DEC_CHK: begin
        // stored entry below the new key: reject
        if (cmp_lt) begin
          status_nxt = bmhq_pkg::ST_NOT_DECREASE;
          state_nxt  = S_DONE;
        end else if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SU_RD;
        end
      end

      S_DEL_RD: begin
        removed_nxt = rd_key;
        state_nxt   = (pos_r == '0) ? S_EX : S_SU_RD;
      end

      S_SU_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SU_CMP;
      end

      S_SU_CMP: begin
        cmp_a = key_r;
        cmp_b = rd_key;
        if (force_r || cmp_lt) begin
          // move the parent down into the hole, follow the hole up
          ram_we    = 1'b1;
          ram_wdata = rd_key;
          pos_nxt   = par_idx;
          if (par_idx == '0) begin
            state_nxt = force_r ? S_EX : S_SU_TOP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = par_up;
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_SU_TOP: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_EX: begin
        count_nxt = last_cnt;
        if (last_cnt == '0) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last_cnt[IW-1:0];
          state_nxt = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        key_nxt   = rd_key;
        pos_nxt   = '0;
        state_nxt = S_SD_L;
      end

      S_SD_L: begin
        if (l_ok) begin
          ram_re    = 1'b1;
          ram_raddr = lchild[IW-1:0];
          state_nxt = S_SD_CL;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_SD_CL: begin
        if (cmp_lt) begin
          best_nxt = rd_key;
          bidx_nxt = lchild[IW-1:0];
        end else begin
          best_nxt = key_r;
          bidx_nxt = pos_r;
        end
        if (r_ok) begin
          ram_re    = 1'b1;
          ram_raddr = rchild[IW-1:0];
          state_nxt = S_SD_CR;
        end else begin
          state_nxt = S_SD_DEC;
        end
      end

      S_SD_CR: begin
        cmp_b = best_r;
        if (cmp_lt) begin
          best_nxt = rd_key;
          bidx_nxt = rchild[IW-1:0];
        end
        state_nxt = S_SD_DEC;
      end

      S_SD_DEC: begin
        ram_we = 1'b1;
        if (bidx_r == pos_r) begin
          state_nxt = S_DONE;
        end else begin
          // pull the smaller child up, follow the hole down
          ram_wdata = best_r;
          pos_nxt   = bidx_r;
          state_nxt = S_SD_L;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // track the root so the minimum never costs a read
    if (ram_we && ram_waddr == '0) begin
      root_nxt = $signed(ram_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      force_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      force_r <= force_nxt;
    end
    pos_r     <= pos_nxt;
    key_r     <= key_nxt;
    best_r    <= best_nxt;
    bidx_r    <= bidx_nxt;
    root_r    <= root_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  `BMHQ_ASSERT_INV(a_count_max, clk, rst_n, count_r <= CNT_MAX, "entry count above capacity")
  `BMHQ_ASSERT(a_sd_pos, clk, rst_n, (state_r == S_SD_L || state_r == S_SD_CL || state_r == S_SD_CR || state_r == S_SD_DEC) |-> ({1'b0, pos_r} < count_r), "sift-down position outside heap")
  `BMHQ_ASSERT(a_wr_in_heap, clk, rst_n, (ram_we && state_r != S_IDLE) |-> ({1'b0, ram_waddr} < count_r), "write beyond last entry")
  `BMHQ_ASSERT(a_count_hold, clk, rst_n, (state_r != S_IDLE && state_r != S_EX) |=> (count_r == $past(count_r)), "entry count changed mid-operation")

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue of signed keys, one RAM read port, one comparator.
// The result is valid on out_ch once the sequencer has walked the tree through the single
// RAM read port, going up or down one level at a time.
// A new command is taken only once the result is in the output register, which holds
// it until the sink takes it.
// Reset (synchronous, rst_n low): heap empty, capacity_limit back to 16.
module binary_min_heap_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  bmhq_in_if.sink                      in_ch,
  bmhq_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [bmhq_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int CW = bmhq_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(bmhq_pkg::MAX_ENTRIES);

  logic [CW-1:0]         capacity_r, capacity_nxt;
  logic [CW-1:0]         limit;
  logic                  out_valid_r, out_valid_nxt;
  bmhq_pkg::res_item_t   out_data_r, out_data_nxt;
  bmhq_pkg::in_item_t    in_item;
  bmhq_pkg::res_item_t   res;
  logic                  res_valid, res_take;

  assign in_item.command    = in_ch.command;
  assign in_item.key_value  = in_ch.key_value;
  assign in_item.heap_index = in_ch.heap_index;

  // cap the programmed limit at the physical depth
  assign limit        = (capacity_r > CNT_MAX) ? CNT_MAX : capacity_r;
  assign capacity_nxt = cfg_we ? cfg_wdata : capacity_r;

  assign res_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  bmhq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .limit    (limit),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= bmhq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_data_r.status;
  assign out_ch.removed_value = out_data_r.removed_value;
  assign out_ch.current_min   = out_data_r.current_min;
  assign out_ch.entry_total   = out_data_r.entry_total;

endmodule

// ===== bench/binary_min_heap_queue_test.sv =====
// Self-checking bench for binary_min_heap_queue: a directed table, then random phases
// under several capacity limits, each result matched to a typed row or a heap predictor.
// Depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and the RTL top level.
`timescale 1ns / 1ps

module binary_min_heap_queue_test;

  localparam int KEY_WIDTH   = bmhq_pkg::KEY_WIDTH;
  localparam int MAX_ENTRIES = bmhq_pkg::MAX_ENTRIES;
  localparam int IDX_W       = bmhq_pkg::IDX_W;
  localparam int CNT_W       = bmhq_pkg::CNT_W;
  localparam int CMD_W       = bmhq_pkg::CMD_W;
  localparam int ST_W        = bmhq_pkg::ST_W;

  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    bit                  set_cap;
    logic [CNT_W-1:0]    cap;
    bmhq_pkg::in_item_t  cmd;
    bit                  typed;
    bmhq_pkg::res_item_t res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  bmhq_in_if  in_ch();
  bmhq_out_if out_ch();

  binary_min_heap_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [KEY_WIDTH-1:0] heap_keys [MAX_ENTRIES];
  int unsigned                 key_count;
  logic [CNT_W-1:0]            cap_limit;

  bmhq_pkg::res_item_t predicted_results [$];
  int                  failures = 0;
  bit                  calm = 1'b0;

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [KEY_WIDTH-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // force_root carries the entry all the way up, as delete needs
  function automatic void sift_up(int unsigned pos, bit force_root);
    int unsigned par;
    while (pos != 0) begin
      par = (pos - 1) / 2;
      if (!force_root && !(heap_keys[par] > heap_keys[pos])) break;
      swap_keys(pos, par);
      pos = par;
    end
  endfunction

  function automatic void sift_down(int unsigned pos);
    int unsigned l, r, low_pos;
    while (pos < key_count) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      low_pos = pos;
      if (l < key_count && heap_keys[l] < heap_keys[low_pos]) low_pos = l;
      if (r < key_count && heap_keys[r] < heap_keys[low_pos]) low_pos = r;
      if (low_pos == pos) break;
      swap_keys(pos, low_pos);
      pos = low_pos;
    end
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] take_root();
    logic signed [KEY_WIDTH-1:0] root;
    root = heap_keys[0];
    key_count--;
    heap_keys[0] = heap_keys[key_count];
    sift_down(0);
    return root;
  endfunction

  function automatic int unsigned heap_limit();
    return (cap_limit > MAX_ENTRIES) ? MAX_ENTRIES : cap_limit;
  endfunction

  function automatic bmhq_pkg::res_item_t apply_command(bmhq_pkg::in_item_t c);
    bmhq_pkg::res_item_t         r;
    logic signed [KEY_WIDTH-1:0] key;
    r = '0;
    r.status = bmhq_pkg::ST_OK;
    key = c.key_value;
    case (c.command)
      bmhq_pkg::CMD_INSERT: begin
        if (key_count >= heap_limit()) begin
          r.status = bmhq_pkg::ST_OVERFLOW;
        end else begin
          heap_keys[key_count] = key;
          key_count++;
          sift_up(key_count - 1, 1'b0);
        end
      end
      bmhq_pkg::CMD_EXTRACT: begin
        if (key_count == 0) r.status = bmhq_pkg::ST_EMPTY;
        else r.removed_value = take_root();
      end
      bmhq_pkg::CMD_DECREASE: begin
        if (c.heap_index >= key_count) begin
          r.status = bmhq_pkg::ST_BAD_INDEX;
        end else if (key > heap_keys[c.heap_index]) begin
          r.status = bmhq_pkg::ST_NOT_DECREASE;
        end else begin
          heap_keys[c.heap_index] = key;
          sift_up(c.heap_index, 1'b0);
        end
      end
      default: begin
        if (c.heap_index >= key_count) begin
          r.status = bmhq_pkg::ST_BAD_INDEX;
        end else begin
          sift_up(c.heap_index, 1'b1);
          r.removed_value = take_root();
        end
      end
    endcase
    r.current_min = (key_count > 0) ? heap_keys[0] : '0;
    r.entry_total = CNT_W'(key_count);
    return r;
  endfunction

  function automatic step_row_t row_cap(logic [CNT_W-1:0] v);
    step_row_t s;
    s = '0;
    s.set_cap = 1'b1;
    s.cap = v;
    return s;
  endfunction

  function automatic step_row_t row_cmd(logic [CMD_W-1:0] cmd,
                                        logic signed [KEY_WIDTH-1:0] key,
                                        logic [IDX_W-1:0] idx);
    step_row_t s;
    s = '0;
    s.cmd.command = cmd;
    s.cmd.key_value = key;
    s.cmd.heap_index = idx;
    return s;
  endfunction

  function automatic step_row_t row_typed(logic [CMD_W-1:0] cmd,
                                          logic signed [KEY_WIDTH-1:0] key,
                                          logic [IDX_W-1:0] idx, logic [ST_W-1:0] st,
                                          logic signed [KEY_WIDTH-1:0] removed,
                                          logic signed [KEY_WIDTH-1:0] root,
                                          logic [CNT_W-1:0] total);
    step_row_t s;
    s = row_cmd(cmd, key, idx);
    s.typed = 1'b1;
    s.res.status = st;
    s.res.removed_value = removed;
    s.res.current_min = root;
    s.res.entry_total = total;
    return s;
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] draw_key();
    int w;
    w = $urandom_range(0, 9);
    if (w < 4) return $urandom;
    if (w < 7) return $signed(KEY_WIDTH'($urandom_range(0, 40))) - 20;
    if (w == 7) return KEY_MAX;
    if (w == 8) return KEY_MIN;
    return $signed(KEY_WIDTH'($urandom_range(0, 1000)));
  endfunction

  function automatic bmhq_pkg::in_item_t draw_command(bit filling);
    bmhq_pkg::in_item_t c;
    int                 w;
    longint             lower;
    w = $urandom_range(0, 99);
    if (filling) begin
      c.command = (w < 55) ? bmhq_pkg::CMD_INSERT : (w < 70) ? bmhq_pkg::CMD_EXTRACT :
                  (w < 85) ? bmhq_pkg::CMD_DECREASE : bmhq_pkg::CMD_DELETE;
    end else begin
      c.command = (w < 15) ? bmhq_pkg::CMD_INSERT : (w < 50) ? bmhq_pkg::CMD_EXTRACT :
                  (w < 65) ? bmhq_pkg::CMD_DECREASE : bmhq_pkg::CMD_DELETE;
    end
    if (key_count > 0 && $urandom_range(0, 9) < 8)
      c.heap_index = IDX_W'($urandom_range(0, key_count - 1));
    else
      c.heap_index = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
    c.key_value = draw_key();
    // mostly a real decrease: a little below the key now held there
    if (c.command == bmhq_pkg::CMD_DECREASE && c.heap_index < key_count &&
        $urandom_range(0, 9) < 7) begin
      lower = longint'(heap_keys[c.heap_index]) - longint'($urandom_range(0, 1000));
      c.key_value = (lower < longint'(KEY_MIN)) ? KEY_MIN : KEY_WIDTH'(lower);
    end
    return c;
  endfunction

  // called at a clock edge; leaves valid high after the transfer
  task automatic send_command(bmhq_pkg::in_item_t c, bit typed,
                              bmhq_pkg::res_item_t typed_res);
    int                  gap;
    bmhq_pkg::res_item_t r;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.command;
    in_ch.key_value  <= c.key_value;
    in_ch.heap_index <= c.heap_index;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_command(c);
    predicted_results.push_back(typed ? typed_res : r);
  endtask

  // write the limit only once every result is back
  task automatic set_capacity(logic [CNT_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_limit = v;
  endtask

  step_row_t directed_steps [$];

  initial begin
    bit filling;
    logic [CNT_W-1:0] phase_caps [10];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = bmhq_pkg::CMD_INSERT;
    in_ch.key_value = '0;
    in_ch.heap_index = '0;
    phase_caps = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd16, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};
    key_count = 0;
    cap_limit = bmhq_pkg::CAP_RESET;
    foreach (heap_keys[i]) heap_keys[i] = '0;

    directed_steps = '{
      row_cap(5'd16),
      row_typed(bmhq_pkg::CMD_EXTRACT, 0, 4'd0, bmhq_pkg::ST_EMPTY, 0, 0, 5'd0),
      row_typed(bmhq_pkg::CMD_DECREASE, 0, 4'd0, bmhq_pkg::ST_BAD_INDEX, 0, 0, 5'd0),
      row_typed(bmhq_pkg::CMD_DELETE, 0, 4'd15, bmhq_pkg::ST_BAD_INDEX, 0, 0, 5'd0),
      row_typed(bmhq_pkg::CMD_INSERT, KEY_MAX, 4'd0, bmhq_pkg::ST_OK, 0, KEY_MAX, 5'd1),
      row_typed(bmhq_pkg::CMD_INSERT, KEY_MIN, 4'd0, bmhq_pkg::ST_OK, 0, KEY_MIN, 5'd2),
      row_cmd(bmhq_pkg::CMD_INSERT, 0, 4'd0),
      row_cmd(bmhq_pkg::CMD_INSERT, -1, 4'd15),
      row_cmd(bmhq_pkg::CMD_INSERT, 32'sh5555_5555, 4'd5),
      row_cmd(bmhq_pkg::CMD_INSERT, 32'shAAAA_AAAA, 4'd10),
      row_cmd(bmhq_pkg::CMD_DECREASE, KEY_MAX, 4'd1),
      row_cmd(bmhq_pkg::CMD_DECREASE, 32'sh5555_5555, 4'd4),
      row_cmd(bmhq_pkg::CMD_DECREASE, KEY_MIN, 4'd3),
      row_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd1),
      row_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd4),
      row_cmd(bmhq_pkg::CMD_EXTRACT, 0, 4'd0),
      row_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd0),
      row_cmd(bmhq_pkg::CMD_EXTRACT, 0, 4'd0),
      row_cmd(bmhq_pkg::CMD_EXTRACT, 0, 4'd0),
      row_typed(bmhq_pkg::CMD_EXTRACT, 0, 4'd0, bmhq_pkg::ST_EMPTY, 0, 0, 5'd0),
      row_cap(5'd1),
      row_typed(bmhq_pkg::CMD_INSERT, 3, 4'd0, bmhq_pkg::ST_OK, 0, 3, 5'd1),
      row_typed(bmhq_pkg::CMD_INSERT, 7, 4'd0, bmhq_pkg::ST_OVERFLOW, 0, 3, 5'd1),
      row_cap(5'd0),
      row_typed(bmhq_pkg::CMD_INSERT, -9, 4'd0, bmhq_pkg::ST_OVERFLOW, 0, 3, 5'd1),
      row_typed(bmhq_pkg::CMD_DELETE, 0, 4'd1, bmhq_pkg::ST_BAD_INDEX, 0, 3, 5'd1),
      row_typed(bmhq_pkg::CMD_EXTRACT, 0, 4'd0, bmhq_pkg::ST_OK, 3, 0, 5'd0)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].set_cap) set_capacity(directed_steps[i].cap);
      else send_command(directed_steps[i].cmd, directed_steps[i].typed, directed_steps[i].res);
    end

    // heap contents carry over between phases, so a lower limit can fall below the count
    filling = 1'b1;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      set_capacity(phase < 10 ? phase_caps[phase] : CNT_W'($urandom_range(0, 31)));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 29) == 0) calm = !calm;
        if (filling && key_count >= heap_limit()) filling = 1'b0;
        else if (!filling && key_count == 0) filling = 1'b1;
        else if ($urandom_range(0, 24) == 0) filling = !filling;
        send_command(draw_command(filling), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stalls, check every transfer against the oldest prediction
  initial begin
    bmhq_pkg::res_item_t want;
    int                  stall;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (predicted_results.size() == 0) begin
        $error("result with no command pending: status %0d", out_ch.status);
        failures++;
      end else begin
        want = predicted_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          failures++;
        end
        if (out_ch.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, actual %0d", want.removed_value,
                 out_ch.removed_value);
          failures++;
        end
        if (out_ch.current_min !== want.current_min) begin
          $error("current_min: expected %0d, actual %0d", want.current_min,
                 out_ch.current_min);
          failures++;
        end
        if (out_ch.entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d, actual %0d", want.entry_total,
                 out_ch.entry_total);
          failures++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
